[design/scs_pkg.sv]
// ----------------------------------------------------------------------------
// Scissor clip stack package
// Command, status and configuration codes plus the stack cell control type.
// ----------------------------------------------------------------------------
package scs_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;
    typedef logic       t_cfg_index;

    localparam t_cmd CMD_PUSH_CLIP = 2'd0;
    localparam t_cmd CMD_POP_CLIP  = 2'd1;
    localparam t_cmd CMD_PUSH_OFF  = 2'd2;
    localparam t_cmd CMD_POP_OFF   = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam t_cfg_index CFG_VP_WIDTH  = 1'b0;
    localparam t_cfg_index CFG_VP_HEIGHT = 1'b1;

    localparam int VP_BITS = 15;
    localparam logic [VP_BITS-1:0] VP_WIDTH_RESET  = 15'd640;
    localparam logic [VP_BITS-1:0] VP_HEIGHT_RESET = 15'd480;

    // Shift control shared by every cell of one stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

[design/scs_in_if.sv]
// ----------------------------------------------------------------------------
// Scissor clip stack command channel
// Valid/ready channel carrying one stack command item.
// ----------------------------------------------------------------------------
interface scs_in_if import scs_pkg::*; ();
    logic               valid;
    logic               ready;
    t_cmd               cmd;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;

    modport source (output valid, cmd, rect_left, rect_top, rect_right, rect_bottom,
                    shift_x, shift_y, input ready);
    modport sink (input valid, cmd, rect_left, rect_top, rect_right, rect_bottom,
                  shift_x, shift_y, output ready);
endinterface

[design/scs_out_if.sv]
// ----------------------------------------------------------------------------
// Scissor clip stack result channel
// Valid/ready channel carrying the active scissor and status of one item.
// ----------------------------------------------------------------------------
interface scs_out_if import scs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] scissor_left;
    logic signed [15:0] scissor_top;
    logic signed [15:0] scissor_right;
    logic signed [15:0] scissor_bottom;
    logic               scissor_changed;
    t_status            status;

    modport source (output valid, scissor_left, scissor_top, scissor_right,
                    scissor_bottom, scissor_changed, status, input ready);
    modport sink (input valid, scissor_left, scissor_top, scissor_right,
                  scissor_bottom, scissor_changed, status, output ready);
endinterface

[design/scs_stack_cell.sv]
// ----------------------------------------------------------------------------
// Scissor clip stack cell
// One entry of a shift stack: take the entry above on push, the one below on pop.
// ----------------------------------------------------------------------------
module scs_stack_cell import scs_pkg::*; #(
    parameter int WIDTH = 64,
    parameter bit CLEAR = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stack_ctl       i_ctl,
    input  logic [WIDTH-1:0] i_from_above,
    input  logic [WIDTH-1:0] i_from_below,
    output logic [WIDTH-1:0] o_entry
);

    logic [WIDTH-1:0] r_entry;
    logic [WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_from_above;
        end else if (i_ctl.pop) begin
            n_entry = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n && CLEAR) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

[design/scissor_clip_stack.sv]
// ----------------------------------------------------------------------------
// Scissor clip stack
// Translation offset stack and clip rectangle stack producing the active scissor.
// ----------------------------------------------------------------------------
// Every command item yields exactly one result item: the active scissor after
// the command, a changed flag (set on a successful clip push or pop) and a
// status (ok, stack full, stack empty / base offset pop). On the accept edge
// the incoming rectangle (or shift) is added to the top offset and saturated
// to the signed COORD_BITS range; in the commit state, once the output
// register is free or being read, the current top clip is clamped into the
// new rectangle, the addressed stack shifts and the result is loaded into
// the output register. The input is ready again only after that commit. Both
// stacks are chains of cells with the top in cell zero; a push shifts every
// entry one cell down, a pop one cell up, so only the two top cells are ever
// read. An empty clip stack reports the viewport (0, 0, viewport_width,
// viewport_height). Overflowing or underflowing commands leave all state
// untouched. Viewport registers are written through the plain configuration
// port and should be changed only while idle.
// ----------------------------------------------------------------------------
module scissor_clip_stack import scs_pkg::*; #(
    parameter int CLIP_DEPTH   = 16,
    parameter int OFFSET_DEPTH = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scs_in_if.sink                i_item,
    scs_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [VP_BITS-1:0]    i_cfg_wdata
);

    localparam int C        = COORD_BITS;
    // sum width: wide enough for a 16 bit field plus a C bit offset
    localparam int EXT_W    = ((C > 16) ? C : 16) + 1;
    localparam int CLIP_W   = 4 * C;
    localparam int OFF_W    = 2 * C;
    localparam int CCNT_W   = $clog2(CLIP_DEPTH + 1);
    localparam int OCNT_W   = $clog2(OFFSET_DEPTH + 1);
    localparam logic signed [EXT_W-1:0] C_MAX =
        {{(EXT_W - C + 1){1'b0}}, {(C - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] C_MIN = ~C_MAX;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_COMMIT = 1'b1;

    function automatic logic signed [C-1:0] sat(input logic signed [EXT_W-1:0] v);
        logic signed [C-1:0] res;
        if (v > C_MAX) begin
            res = C_MAX[C-1:0];
        end else if (v < C_MIN) begin
            res = C_MIN[C-1:0];
        end else begin
            res = v[C-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [C-1:0] smin(input logic signed [C-1:0] a,
                                                input logic signed [C-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [C-1:0] smax(input logic signed [C-1:0] a,
                                                input logic signed [C-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [C-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    logic                 r_state;
    logic                 n_state;
    logic [CCNT_W-1:0]    r_clip_cnt;
    logic [OCNT_W-1:0]    r_off_cnt;
    logic [VP_BITS-1:0]   r_vp_width;
    logic [VP_BITS-1:0]   r_vp_height;

    // captured item: command and the four saturated sums
    t_cmd                 r_cmd;
    logic signed [C-1:0]  r_sum_l;
    logic signed [C-1:0]  r_sum_t;
    logic signed [C-1:0]  r_sum_r;
    logic signed [C-1:0]  r_sum_b;

    // output register
    logic                 r_out_valid;
    logic signed [15:0]   r_out_l;
    logic signed [15:0]   r_out_t;
    logic signed [15:0]   r_out_r;
    logic signed [15:0]   r_out_b;
    logic                 r_out_changed;
    t_status              r_out_status;

    // ------------------------------------------------------------------
    // Stack chains
    // ------------------------------------------------------------------
    logic [CLIP_W-1:0]    w_clip [CLIP_DEPTH];
    logic [OFF_W-1:0]     w_off  [OFFSET_DEPTH];
    logic [CLIP_W-1:0]    w_clip_new;
    logic [OFF_W-1:0]     w_off_new;
    t_stack_ctl           w_clip_ctl;
    t_stack_ctl           w_off_ctl;

    genvar gi;
    generate
        for (gi = 0; gi < CLIP_DEPTH; gi++) begin : g_clip
            scs_stack_cell #(
                .WIDTH (CLIP_W),
                .CLEAR (1'b0)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_clip_ctl),
                .i_from_above ((gi == 0) ? w_clip_new : w_clip[(gi == 0) ? 0 : gi - 1]),
                .i_from_below ((gi == CLIP_DEPTH - 1) ? '0 :
                               w_clip[(gi == CLIP_DEPTH - 1) ? gi : gi + 1]),
                .o_entry      (w_clip[gi])
            );
        end
        for (gi = 0; gi < OFFSET_DEPTH; gi++) begin : g_off
            // the top cell holds the (0,0) base entry after reset
            scs_stack_cell #(
                .WIDTH (OFF_W),
                .CLEAR (gi == 0)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_off_ctl),
                .i_from_above ((gi == 0) ? w_off_new : w_off[(gi == 0) ? 0 : gi - 1]),
                .i_from_below ((gi == OFFSET_DEPTH - 1) ? '0 :
                               w_off[(gi == OFFSET_DEPTH - 1) ? gi : gi + 1]),
                .o_entry      (w_off[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Accept side: add the top offset to the incoming coordinates
    // ------------------------------------------------------------------
    logic                 w_accept;
    logic signed [C-1:0]  w_off_x;
    logic signed [C-1:0]  w_off_y;
    logic signed [15:0]   w_a_l;
    logic signed [15:0]   w_a_t;

    assign w_accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_off_x = w_off[0][C-1:0];
    assign w_off_y = w_off[0][OFF_W-1:C];

    // a push offset reuses the left/top adders for its shift
    assign w_a_l = (i_item.cmd == CMD_PUSH_OFF) ? i_item.shift_x : i_item.rect_left;
    assign w_a_t = (i_item.cmd == CMD_PUSH_OFF) ? i_item.shift_y : i_item.rect_top;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_item.cmd;
            r_sum_l <= sat(EXT_W'(w_a_l) + EXT_W'(w_off_x));
            r_sum_t <= sat(EXT_W'(w_a_t) + EXT_W'(w_off_y));
            r_sum_r <= sat(EXT_W'(i_item.rect_right) + EXT_W'(w_off_x));
            r_sum_b <= sat(EXT_W'(i_item.rect_bottom) + EXT_W'(w_off_y));
        end
    end

    // ------------------------------------------------------------------
    // Commit side: clamp, shift the stacks, load the result
    // ------------------------------------------------------------------
    logic                 w_commit;
    logic                 w_clip_full;
    logic                 w_clip_empty;
    logic                 w_off_full;
    logic                 w_off_base;
    logic signed [C-1:0]  w_top_l, w_top_t, w_top_r, w_top_b;
    logic signed [C-1:0]  w_nxt_l, w_nxt_t, w_nxt_r, w_nxt_b;
    logic signed [C-1:0]  w_new_l, w_new_t, w_new_r, w_new_b;
    logic signed [C-1:0]  w_vp_r, w_vp_b;
    logic signed [C-1:0]  w_act_l, w_act_t, w_act_r, w_act_b;
    logic                 w_changed;
    t_status              w_status;

    assign w_commit     = (r_state == S_COMMIT) && (!r_out_valid || o_result.ready);
    assign w_clip_full  = (r_clip_cnt >= CCNT_W'(CLIP_DEPTH));
    assign w_clip_empty = (r_clip_cnt == '0);
    assign w_off_full   = (r_off_cnt >= OCNT_W'(OFFSET_DEPTH));
    assign w_off_base   = (r_off_cnt <= OCNT_W'(1));

    assign {w_top_b, w_top_r, w_top_t, w_top_l} = w_clip[0];
    assign {w_nxt_b, w_nxt_r, w_nxt_t, w_nxt_l} = w_clip[1];

    assign w_vp_r = sat(EXT_W'(r_vp_width));
    assign w_vp_b = sat(EXT_W'(r_vp_height));

    // clamp each edge of the current top into the shifted rectangle
    always_comb begin
        if (w_clip_empty) begin
            w_new_l = r_sum_l;
            w_new_t = r_sum_t;
            w_new_r = r_sum_r;
            w_new_b = r_sum_b;
        end else begin
            w_new_l = smin(smax(w_top_l, r_sum_l), r_sum_r);
            w_new_t = smin(smax(w_top_t, r_sum_t), r_sum_b);
            w_new_r = smax(smin(w_top_r, r_sum_r), r_sum_l);
            w_new_b = smax(smin(w_top_b, r_sum_b), r_sum_t);
        end
    end

    assign w_clip_new = {w_new_b, w_new_r, w_new_t, w_new_l};
    assign w_off_new  = {r_sum_t, r_sum_l};

    always_comb begin
        w_clip_ctl = '0;
        w_off_ctl  = '0;
        w_changed  = 1'b0;
        w_status   = ST_OK;
        // hold the active scissor unless a clip command changes it
        w_act_l = w_clip_empty ? '0 : w_top_l;
        w_act_t = w_clip_empty ? '0 : w_top_t;
        w_act_r = w_clip_empty ? w_vp_r : w_top_r;
        w_act_b = w_clip_empty ? w_vp_b : w_top_b;
        case (r_cmd)
            CMD_PUSH_CLIP: begin
                if (w_clip_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_clip_ctl.push = w_commit;
                    w_changed = 1'b1;
                    w_act_l = w_new_l;
                    w_act_t = w_new_t;
                    w_act_r = w_new_r;
                    w_act_b = w_new_b;
                end
            end
            CMD_POP_CLIP: begin
                if (w_clip_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_clip_ctl.pop = w_commit;
                    w_changed = 1'b1;
                    // the entry below becomes the top, or the viewport
                    if (r_clip_cnt == CCNT_W'(1)) begin
                        w_act_l = '0;
                        w_act_t = '0;
                        w_act_r = w_vp_r;
                        w_act_b = w_vp_b;
                    end else begin
                        w_act_l = w_nxt_l;
                        w_act_t = w_nxt_t;
                        w_act_r = w_nxt_r;
                        w_act_b = w_nxt_b;
                    end
                end
            end
            CMD_PUSH_OFF: begin
                if (w_off_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_off_ctl.push = w_commit;
                end
            end
            CMD_POP_OFF: begin
                if (w_off_base) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_off_ctl.pop = w_commit;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clip_cnt  <= '0;
            r_off_cnt   <= OCNT_W'(1);
            r_out_valid <= 1'b0;
            r_vp_width  <= VP_WIDTH_RESET;
            r_vp_height <= VP_HEIGHT_RESET;
        end else begin
            r_state <= n_state;
            if (w_clip_ctl.push) begin
                r_clip_cnt <= r_clip_cnt + CCNT_W'(1);
            end else if (w_clip_ctl.pop) begin
                r_clip_cnt <= r_clip_cnt - CCNT_W'(1);
            end
            if (w_off_ctl.push) begin
                r_off_cnt <= r_off_cnt + OCNT_W'(1);
            end else if (w_off_ctl.pop) begin
                r_off_cnt <= r_off_cnt - OCNT_W'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VP_WIDTH:  r_vp_width  <= i_cfg_wdata;
                    CFG_VP_HEIGHT: r_vp_height <= i_cfg_wdata;
                    default: begin
                        r_vp_width <= r_vp_width;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_l       <= to_out(w_act_l);
            r_out_t       <= to_out(w_act_t);
            r_out_r       <= to_out(w_act_r);
            r_out_b       <= to_out(w_act_b);
            r_out_changed <= w_changed;
            r_out_status  <= w_status;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.scissor_left    = r_out_l;
    assign o_result.scissor_top     = r_out_t;
    assign o_result.scissor_right   = r_out_r;
    assign o_result.scissor_bottom  = r_out_b;
    assign o_result.scissor_changed = r_out_changed;
    assign o_result.status          = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_off_base_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_off_cnt != '0) && (r_off_cnt <= OCNT_W'(OFFSET_DEPTH)))
        else $error("offset stack lost its base entry or overflowed");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip_cnt <= CCNT_W'(CLIP_DEPTH))
        else $error("clip stack count beyond depth");

    a_accept_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_COMMIT))
        else $error("accepted item not moved to commit");

    a_shift_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clip_ctl.push || w_clip_ctl.pop || w_off_ctl.push || w_off_ctl.pop)
        |-> w_commit)
        else $error("stack shifted outside commit");

    a_changed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.scissor_changed) |-> (o_result.status == ST_OK))
        else $error("scissor change reported with error status");

endmodule

[test/tb_scissor_clip_stack.sv]
// ----------------------------------------------------------------------------
// Scissor clip stack testbench
// Drives stack command items through the valid/ready channel and checks every
// result item against a cycle-free model of both stacks and the viewport.
// ----------------------------------------------------------------------------
// A short directed run covers the empty and base-pop refusals, coordinate
// saturation at both rails, inverted rectangles and ignored fields. Random
// segments then lean toward filling or draining one stack at a time, so both
// stacks overflow and underflow many times. The viewport is rewritten between
// phases, and the mix of sender and receiver idling changes twice over them.
// ----------------------------------------------------------------------------
module tb_scissor_clip_stack;
    import scs_pkg::*;

    localparam int CLIP_SLOTS       = 16;
    localparam int OFFSET_SLOTS     = 16;
    localparam int COORD_MAX        = 32767;
    localparam int COORD_MIN        = -32768;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int SETTLE_CYCLES    = 4;
    localparam int MAX_REPORTS      = 40;

    // One command item as it goes onto the channel
    typedef struct {
        t_cmd               cmd;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
    } t_cmd_item;

    typedef struct {
        int left;
        int top;
        int right;
        int bottom;
    } t_rect;

    // Scissor that one item should report
    typedef struct {
        t_rect   area;
        logic    changed;
        t_status status;
    } t_scissor;

    // Random segments favor one kind of command to push a stack to its limits
    typedef enum int {
        SEG_CLIP_FILL,
        SEG_CLIP_DRAIN,
        SEG_OFF_FILL,
        SEG_OFF_DRAIN,
        SEG_MIXED
    } t_seg_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_cfg_index           cfg_index;
    logic [VP_BITS-1:0]   cfg_wdata;

    scs_in_if  cmd_if ();
    scs_out_if res_if ();

    scissor_clip_stack #(
        .CLIP_DEPTH   (CLIP_SLOTS),
        .OFFSET_DEPTH (OFFSET_SLOTS),
        .COORD_BITS   (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (cmd_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Items waiting for the driver and scissors waiting for the block
    t_cmd_item pending_cmds[$];
    t_scissor  scissor_expected[$];

    // Model state: both stacks plus the viewport registers
    t_rect clip_stack [CLIP_SLOTS];
    int    clip_depth;
    int    shift_stack_x [OFFSET_SLOTS];
    int    shift_stack_y [OFFSET_SLOTS];
    int    shift_depth;
    int    vp_width;
    int    vp_height;

    int    send_idle_pct;
    int    recv_idle_pct;
    logic  item_taken;

    int    errors;
    int    reports;
    int    items_seen;
    int    full_refusals;
    int    empty_refusals;
    int    deepest_clip;
    int    deepest_shift;

    t_seg_kind seg_kind;
    int        seg_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic int clamp_coord(int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic int lesser(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int greater(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // Apply one item to the model stacks and return the scissor it reports
    function automatic t_scissor apply_command(t_cmd_item c);
        t_scissor res;
        t_rect    r;
        t_rect    cur;
        t_rect    nest;
        int       ox;
        int       oy;
        ox = shift_stack_x[shift_depth-1];
        oy = shift_stack_y[shift_depth-1];
        res.changed = 1'b0;
        res.status  = ST_OK;
        case (c.cmd)
            CMD_PUSH_CLIP: begin
                if (clip_depth >= CLIP_SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    r.left   = clamp_coord(int'(c.rect_left) + ox);
                    r.top    = clamp_coord(int'(c.rect_top) + oy);
                    r.right  = clamp_coord(int'(c.rect_right) + ox);
                    r.bottom = clamp_coord(int'(c.rect_bottom) + oy);
                    if (clip_depth > 0) begin
                        // Clamp every edge of the current top into the new rectangle,
                        // edge order notwithstanding
                        cur = clip_stack[clip_depth-1];
                        nest.left   = lesser(greater(cur.left, r.left), r.right);
                        nest.top    = lesser(greater(cur.top, r.top), r.bottom);
                        nest.right  = greater(lesser(cur.right, r.right), r.left);
                        nest.bottom = greater(lesser(cur.bottom, r.bottom), r.top);
                        r = nest;
                    end
                    clip_stack[clip_depth] = r;
                    clip_depth++;
                    res.changed = 1'b1;
                end
            end
            CMD_POP_CLIP: begin
                if (clip_depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    clip_depth--;
                    res.changed = 1'b1;
                end
            end
            CMD_PUSH_OFF: begin
                if (shift_depth >= OFFSET_SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    shift_stack_x[shift_depth] = clamp_coord(ox + int'(c.shift_x));
                    shift_stack_y[shift_depth] = clamp_coord(oy + int'(c.shift_y));
                    shift_depth++;
                end
            end
            default: begin
                // The base offset never leaves the stack
                if (shift_depth <= 1) res.status = ST_EMPTY;
                else shift_depth--;
            end
        endcase
        if (clip_depth > 0) begin
            res.area = clip_stack[clip_depth-1];
        end else begin
            res.area.left   = 0;
            res.area.top    = 0;
            res.area.right  = vp_width;
            res.area.bottom = vp_height;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_item(t_cmd cmd, int l, int t, int r, int b, int sx, int sy);
        t_cmd_item it;
        it.cmd         = cmd;
        it.rect_left   = 16'(l);
        it.rect_top    = 16'(t);
        it.rect_right  = 16'(r);
        it.rect_bottom = 16'(b);
        it.shift_x     = 16'(sx);
        it.shift_y     = 16'(sy);
        pending_cmds = {pending_cmds, it};
    endtask

    function automatic t_cmd pick_command(t_seg_kind k);
        t_cmd favored;
        case (k)
            SEG_CLIP_FILL:  favored = CMD_PUSH_CLIP;
            SEG_CLIP_DRAIN: favored = CMD_POP_CLIP;
            SEG_OFF_FILL:   favored = CMD_PUSH_OFF;
            SEG_OFF_DRAIN:  favored = CMD_POP_OFF;
            default:        return t_cmd'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 99) < 70) return favored;
        return t_cmd'($urandom_range(0, 3));
    endfunction

    // Random content for one item; unused fields always carry noise
    function automatic t_cmd_item make_item(t_cmd cmd);
        t_cmd_item it;
        int        x0;
        int        y0;
        int        pick;
        it.cmd         = cmd;
        it.rect_left   = 16'($urandom);
        it.rect_top    = 16'($urandom);
        it.rect_right  = 16'($urandom);
        it.rect_bottom = 16'($urandom);
        it.shift_x     = 16'($urandom);
        it.shift_y     = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (cmd == CMD_PUSH_CLIP && pick < 75) begin
            // Mostly overlapping on-screen rectangles so nesting does real clamping
            x0 = int'($urandom_range(0, 900)) - 200;
            y0 = int'($urandom_range(0, 700)) - 200;
            it.rect_left = 16'(x0);
            it.rect_top  = 16'(y0);
            if (pick < 60) begin
                it.rect_right  = 16'(x0 + int'($urandom_range(0, 600)));
                it.rect_bottom = 16'(y0 + int'($urandom_range(0, 500)));
            end else begin
                it.rect_right  = 16'(x0 - int'($urandom_range(1, 300)));
                it.rect_bottom = 16'(y0 - int'($urandom_range(1, 300)));
            end
        end
        if (cmd == CMD_PUSH_OFF) begin
            if (pick < 60) begin
                it.shift_x = 16'(int'($urandom_range(0, 400)) - 200);
                it.shift_y = 16'(int'($urandom_range(0, 400)) - 200);
            end else if (pick < 80) begin
                it.shift_x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                it.shift_y = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
        end
        return it;
    endfunction

    task automatic write_reg(t_cfg_index idx, int value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= VP_BITS'(value);
        if (idx == CFG_VP_WIDTH) vp_width = value;
        else vp_height = value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Hold until every item is sent and answered, then let the pipeline drain
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || scissor_expected.size() != 0 || cmd_if.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    task automatic check_result();
        t_scissor want;
        if (scissor_expected.size() == 0) begin
            errors++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: result item with nothing expected, expected none, actual %0h %0h %0h %0h",
                         $time, res_if.scissor_left, res_if.scissor_top,
                         res_if.scissor_right, res_if.scissor_bottom);
            end
        end else begin
            want = scissor_expected.pop_front();
            compare_field("scissor_left", 16'(want.area.left), res_if.scissor_left);
            compare_field("scissor_top", 16'(want.area.top), res_if.scissor_top);
            compare_field("scissor_right", 16'(want.area.right), res_if.scissor_right);
            compare_field("scissor_bottom", 16'(want.area.bottom), res_if.scissor_bottom);
            compare_field("scissor_changed", 16'(want.changed), 16'(res_if.scissor_changed));
            compare_field("status", 16'(want.status), 16'(res_if.status));
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_cmd_item it;
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        // Hold the current item until it is taken, then advance or go idle
        if (i_rst_n && (!cmd_if.valid || item_taken)) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = pending_cmds.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.cmd         <= it.cmd;
                cmd_if.rect_left   <= it.rect_left;
                cmd_if.rect_top    <= it.rect_top;
                cmd_if.rect_right  <= it.rect_right;
                cmd_if.rect_bottom <= it.rect_bottom;
                cmd_if.shift_x     <= it.shift_x;
                cmd_if.shift_y     <= it.shift_y;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd_item seen;
        t_scissor  want;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= cmd_if.valid && cmd_if.ready;
            // Check the result first: an item accepted now cannot answer on this edge
            if (res_if.valid && res_if.ready) check_result();
            if (cmd_if.valid && cmd_if.ready) begin
                seen.cmd         = cmd_if.cmd;
                seen.rect_left   = cmd_if.rect_left;
                seen.rect_top    = cmd_if.rect_top;
                seen.rect_right  = cmd_if.rect_right;
                seen.rect_bottom = cmd_if.rect_bottom;
                seen.shift_x     = cmd_if.shift_x;
                seen.shift_y     = cmd_if.shift_y;
                want = apply_command(seen);
                scissor_expected = {scissor_expected, want};
                items_seen++;
                if (want.status == ST_FULL) full_refusals++;
                if (want.status == ST_EMPTY) empty_refusals++;
                deepest_clip  = greater(deepest_clip, clip_depth);
                deepest_shift = greater(deepest_shift, shift_depth);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed items, then random phases
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_VP_WIDTH;
        cfg_wdata          = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.cmd         = CMD_PUSH_CLIP;
        cmd_if.rect_left   = '0;
        cmd_if.rect_top    = '0;
        cmd_if.rect_right  = '0;
        cmd_if.rect_bottom = '0;
        cmd_if.shift_x     = '0;
        cmd_if.shift_y     = '0;
        res_if.ready       = 1'b0;
        send_idle_pct      = 29;
        recv_idle_pct      = 54;
        errors             = 0;
        reports            = 0;
        items_seen         = 0;
        full_refusals      = 0;
        empty_refusals     = 0;
        deepest_clip       = 0;
        deepest_shift      = 1;
        seg_left           = 0;
        seg_kind           = SEG_MIXED;
        // Model reset: empty clip stack, base offset (0,0), reset viewport
        clip_depth         = 0;
        shift_depth        = 1;
        shift_stack_x[0]   = 0;
        shift_stack_y[0]   = 0;
        vp_width           = int'(VP_WIDTH_RESET);
        vp_height          = int'(VP_HEIGHT_RESET);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset viewport still in place
        queue_item(CMD_POP_CLIP, 5, 6, 7, 8, 9, 10);              // pop on empty clip stack
        queue_item(CMD_POP_OFF, 0, 0, 0, 0, 0, 0);                // pop of the base offset
        queue_item(CMD_PUSH_CLIP, -32768, -32768, 32767, 32767, 32767, -32768);
        queue_item(CMD_PUSH_OFF, -32768, 32767, -1, 0, 32767, -32768);
        queue_item(CMD_PUSH_CLIP, 1, -1, 2, -2, 0, 0);            // sums hit both rails
        queue_item(CMD_PUSH_OFF, 0, 0, 0, 0, 100, 100);           // offset saturates again
        queue_item(CMD_POP_OFF, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_OFF, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_OFF, 0, 0, 0, 0, 0, 0);                // back to base: refused
        queue_item(CMD_PUSH_CLIP, 300, 400, 100, 50, -7, 7);      // inverted rectangle
        queue_item(CMD_PUSH_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_PUSH_CLIP, -5, -5, 1000, 1000, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);               // empty again: refused
        queue_item(CMD_PUSH_OFF, 1, 2, 3, 4, -32768, 32767);
        queue_item(CMD_PUSH_CLIP, 0, 0, 639, 479, 55, -55);
        queue_item(CMD_PUSH_CLIP, 32767, 32767, -32768, -32768, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_CLIP, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_POP_OFF, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                // Rewrite the viewport only with nothing in flight
                wait_idle();
                case (phase)
                    1: begin
                        write_reg(CFG_VP_WIDTH, 0);
                        write_reg(CFG_VP_HEIGHT, 0);
                    end
                    2: begin
                        write_reg(CFG_VP_WIDTH, 32767);
                        write_reg(CFG_VP_HEIGHT, 32767);
                    end
                    3: begin
                        write_reg(CFG_VP_WIDTH, int'($urandom_range(0, 32767)));
                        write_reg(CFG_VP_HEIGHT, int'($urandom_range(0, 32767)));
                    end
                    default: begin
                        write_reg(CFG_VP_WIDTH, 1920);
                        write_reg(CFG_VP_HEIGHT, 1080);
                    end
                endcase
            end
            // Receiver-heavy idling first, sender-heavy next, then full rate
            if (phase < 2) begin
                send_idle_pct = 29;
                recv_idle_pct = 54;
            end else if (phase < 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (seg_left == 0) begin
                    seg_kind = t_seg_kind'($urandom_range(0, 4));
                    seg_left = $urandom_range(20, 50);
                end
                seg_left--;
                pending_cmds = {pending_cmds, make_item(pick_command(seg_kind))};
            end
        end

        wait_idle();
        $display("Ran %0d items over %0d viewport settings: %0d full and %0d empty refusals,",
                 items_seen, PHASES, full_refusals, empty_refusals);
        $display("deepest clip stack %0d, deepest offset stack %0d, %0d mismatches",
                 deepest_clip, deepest_shift, errors);
        if (errors == 0) begin
            $display("scissor_clip_stack regression: pass");
        end else begin
            $display("scissor_clip_stack regression: fail");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #2000000;
        $display("scissor_clip_stack regression: fail");
        $finish;
    end

endmodule

[sim.f]
design/scs_pkg.sv
design/scs_in_if.sv
design/scs_out_if.sv
design/scs_stack_cell.sv
design/scissor_clip_stack.sv
test/tb_scissor_clip_stack.sv
